[sv/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; expects clk and rst in scope where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/pda_pkg.sv]
// shared types and constants for the difficulty adjustment core
// no dependencies
`default_nettype none

package pda_pkg;

  // widths of the header fields, the adjust factor and the bomb exponent
  localparam int unsigned WORD_W = 64;
  localparam int unsigned RANK_W = 4;
  localparam int unsigned FAC_W  = 7;
  localparam int unsigned EXP_W  = 6;

  // difficulty floor
  localparam logic [WORD_W-1:0] MIN_WORK = 64'h0000_0000_0002_0000;

  // fork ranks, compared as ordered
  localparam logic [RANK_W-1:0] RANK_HOMESTEAD      = 4'd1;
  localparam logic [RANK_W-1:0] RANK_BYZANTIUM      = 4'd4;
  localparam logic [RANK_W-1:0] RANK_CONSTANTINOPLE = 4'd5;
  localparam logic [RANK_W-1:0] RANK_LONDON         = 4'd9;

  // adjustment rule constants
  localparam logic [FAC_W-1:0] ADJ_CAP      = 7'd99;
  localparam logic [3:0]       FRONTIER_GAP = 4'd13;

  // gap / 9 and gap / 10 for gaps below 1024: (g * m) >> 13
  localparam logic [9:0] DIV9_MUL  = 10'd911;
  localparam logic [9:0] DIV10_MUL = 10'd820;

  // bomb delays in blocks
  localparam logic [23:0] DELAY_GRAY   = 24'd11400000;
  localparam logic [23:0] DELAY_ARROW  = 24'd10700000;
  localparam logic [23:0] DELAY_LONDON = 24'd9700000;
  localparam logic [23:0] DELAY_MUIR   = 24'd9000000;
  localparam logic [23:0] DELAY_CONST  = 24'd5000000;
  localparam logic [23:0] DELAY_BYZ    = 24'd3000000;

  // bomb period 100000 = 32 * 3125; /3125 as (v * 343598) >> 30 for v < 2^18
  // periods past this limit push the exponent to 64 or more
  localparam logic [22:0] BOMB_LIMIT = 23'd6600000;
  localparam logic [18:0] BOMB_MUL   = 19'd343598;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_GRAY  = 2'd0,
    CFG_ARROW = 2'd1,
    CFG_MUIR  = 2'd2
  } cfg_idx_t;

  // bomb term decoded from height and fork state
  typedef struct packed {
    logic             ovf;
    logic             on;
    logic [EXP_W-1:0] exp;
  } bomb_t;

  // parent-relative adjustment: add or subtract fac * (parent >> 11)
  typedef struct packed {
    logic             add;
    logic [FAC_W-1:0] fac;
  } adj_t;

endpackage

`default_nettype wire

[sv/pow_difficulty_adjust_core.sv]
// top level of the proof-of-work difficulty adjustment core
// depends on pda_pkg and pda_bomb
//
//   channel   handshake                 payload
//   header    start / busy              block_height block_time parent_time
//                                       parent_work parent_uncles fork_rank
//   config    cfg_valid / cfg_ready     cfg_index cfg_data
//   result    done (one-cycle strobe)   next_work overflowed
//
// one header per cycle while busy is low; each taken start goes through these steps in order
// (input register, adjust decode and bomb decode, adjust multiply, bomb add and clamp)
// busy and cfg_ready hold off only during reset and for the cycle after it
// rst is synchronous and flushes all words in flight; glacier registers return to all ones
// results cannot be stalled, so the pipeline never stops
`default_nettype none

module pow_difficulty_adjust_core import pda_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [WORD_W-1:0] block_height,
  input  wire logic [WORD_W-1:0] block_time,
  input  wire logic [WORD_W-1:0] parent_time,
  input  wire logic [WORD_W-1:0] parent_work,
  input  wire logic              parent_uncles,
  input  wire logic [RANK_W-1:0] fork_rank,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data,
  output logic                   done,
  output logic [WORD_W-1:0]      next_work,
  output logic                   overflowed
);

  // glacier fork registers
  logic [WORD_W-1:0] gray_glacier_start;
  logic [WORD_W-1:0] arrow_glacier_start;
  logic [WORD_W-1:0] muir_glacier_start;

  // input register
  logic              in_valid;
  logic [WORD_W-1:0] in_height, in_gap, in_work;
  logic              in_uncles;
  logic [RANK_W-1:0] in_rank;

  // stage 1 register
  logic              s1_valid;
  logic [WORD_W-1:0] s1_work;
  adj_t              s1_adj;
  bomb_t             s1_bomb;

  // stage 2 register
  logic              s2_valid;
  logic [WORD_W-1:0] s2_work;
  logic              s2_ovf;
  bomb_t             s2_bomb;

  adj_t              adj;
  bomb_t             bomb;
  logic              gap_big;
  logic [19:0]       p9, p10;
  logic [FAC_W-1:0]  z9, z10, y, excess;
  logic [59:0]       prod;
  logic [WORD_W:0]   adj_sum;
  logic [WORD_W-1:0] adj_work;
  logic              adj_ovf;
  logic [WORD_W-1:0] bomb_val;
  logic [WORD_W:0]   bomb_sum;
  logic              fin_ovf;

  // busy only during reset and in the cycle after it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = !busy;

  // configuration writes; index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      gray_glacier_start  <= '1;
      arrow_glacier_start <= '1;
      muir_glacier_start  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRAY:  gray_glacier_start  <= cfg_data;
        CFG_ARROW: arrow_glacier_start <= cfg_data;
        CFG_MUIR:  muir_glacier_start  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register, gap taken modulo 2^64
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_height <= block_height;
    in_gap    <= block_time - parent_time;
    in_work   <= parent_work;
    in_uncles <= parent_uncles;
    in_rank   <= fork_rank;
  end

  // gap / 9 and gap / 10, saturated once the cap is certain
  assign gap_big = |in_gap[63:10];
  assign p9      = {10'd0, in_gap[9:0]} * {10'd0, DIV9_MUL};
  assign p10     = {10'd0, in_gap[9:0]} * {10'd0, DIV10_MUL};
  assign z9      = gap_big ? '1 : p9[19:13];
  assign z10     = gap_big ? '1 : p10[19:13];

  // adjustment rule by fork rank
  always_comb begin
    y      = '0;
    excess = '0;
    adj    = '0;
    priority if (in_rank >= RANK_BYZANTIUM) begin
      y = in_uncles ? 7'd2 : 7'd1;
      if (z9 <= y) begin
        adj.add = 1'b1;
        adj.fac = y - z9;
      end else begin
        excess  = z9 - y;
        adj.add = 1'b0;
        adj.fac = (excess > ADJ_CAP) ? ADJ_CAP : excess;
      end
    end else if (in_rank >= RANK_HOMESTEAD) begin
      y = 7'd1;
      if (z10 <= y) begin
        adj.add = 1'b1;
        adj.fac = y - z10;
      end else begin
        excess  = z10 - y;
        adj.add = 1'b0;
        adj.fac = (excess > ADJ_CAP) ? ADJ_CAP : excess;
      end
    end else begin
      adj.add = !(|in_gap[63:4]) && (in_gap[3:0] < FRONTIER_GAP);
      adj.fac = 7'd1;
    end
  end

  pda_bomb u_bomb (
    .block_height        (in_height),
    .fork_rank           (in_rank),
    .gray_glacier_start  (gray_glacier_start),
    .arrow_glacier_start (arrow_glacier_start),
    .muir_glacier_start  (muir_glacier_start),
    .bomb                (bomb)
  );

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_work <= in_work;
    s1_adj  <= adj;
    s1_bomb <= bomb;
  end

  // parent adjustment: fac * (parent >> 11), never below zero on subtract
  assign prod     = {53'd0, s1_adj.fac} * {7'd0, s1_work[63:11]};
  assign adj_sum  = {1'b0, s1_work} + {5'd0, prod};
  assign adj_work = s1_adj.add ? adj_sum[WORD_W-1:0] : (s1_work - {4'd0, prod});
  assign adj_ovf  = s1_adj.add && adj_sum[WORD_W];

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_work <= adj_work;
    s2_ovf  <= adj_ovf;
    s2_bomb <= s1_bomb;
  end

  // bomb term and overflow
  assign bomb_val = s2_bomb.on ? ({{(WORD_W-1){1'b0}}, 1'b1} << s2_bomb.exp) : '0;
  assign bomb_sum = {1'b0, s2_work} + {1'b0, bomb_val};
  assign fin_ovf  = s2_ovf || s2_bomb.ovf || bomb_sum[WORD_W];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ovf) begin
      next_work  <= '1;
      overflowed <= 1'b1;
    end else begin
      next_work  <= (bomb_sum[WORD_W-1:0] < MIN_WORK) ? MIN_WORK : bomb_sum[WORD_W-1:0];
      overflowed <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[sv/pda_bomb.sv]
// difficulty bomb decode: delay selection and exponent of the bomb term
// depends on pda_pkg
`default_nettype none

module pda_bomb import pda_pkg::*; (
  input  wire logic [WORD_W-1:0] block_height,
  input  wire logic [RANK_W-1:0] fork_rank,
  input  wire logic [WORD_W-1:0] gray_glacier_start,
  input  wire logic [WORD_W-1:0] arrow_glacier_start,
  input  wire logic [WORD_W-1:0] muir_glacier_start,
  output bomb_t                  bomb
);

  logic        gray_on, arrow_on, muir_on;
  logic [23:0] delay;
  logic        above;
  logic [WORD_W-1:0] diff;
  logic        far;
  logic [36:0] quot_prod;
  logic [6:0]  periods;
  logic [6:0]  exp_wide;

  // fork is live when configured and reached
  assign gray_on  = (gray_glacier_start != '1) && (block_height >= gray_glacier_start);
  assign arrow_on = (arrow_glacier_start != '1) && (block_height >= arrow_glacier_start);
  assign muir_on  = (muir_glacier_start != '1) && (block_height >= muir_glacier_start);

  // delay by fork priority
  always_comb begin
    priority if (gray_on) begin
      delay = DELAY_GRAY;
    end else if (arrow_on) begin
      delay = DELAY_ARROW;
    end else if (fork_rank >= RANK_LONDON) begin
      delay = DELAY_LONDON;
    end else if (muir_on) begin
      delay = DELAY_MUIR;
    end else if (fork_rank >= RANK_CONSTANTINOPLE) begin
      delay = DELAY_CONST;
    end else if (fork_rank >= RANK_BYZANTIUM) begin
      delay = DELAY_BYZ;
    end else begin
      delay = '0;
    end
  end

  // fake height and period count
  assign above     = block_height > {40'd0, delay};
  assign diff      = block_height - {40'd0, delay};
  assign far       = (|diff[63:23]) || (diff[22:0] >= BOMB_LIMIT);
  assign quot_prod = {19'd0, diff[22:5]} * {18'd0, BOMB_MUL};
  assign periods   = quot_prod[36:30];
  assign exp_wide  = periods - 7'd2;

  // bomb term fields
  assign bomb.ovf = above && far;
  assign bomb.on  = above && !far && (periods >= 7'd2);
  assign bomb.exp = exp_wide[EXP_W-1:0];

endmodule

`default_nettype wire

[sv/pda_checker.sv]
// port-level checks for pow_difficulty_adjust_core, bound to the top level
// depends on pda_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module pda_checker import pda_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic [WORD_W-1:0] next_work,
  input wire logic              overflowed
);

  // every taken header gives a result word
  `ASSERT_CLK(a_latency, (start && !busy) |-> ##4 done, "result word missing after start")

  // no word without a header taken before it
  `ASSERT_CLK(a_no_spurious, done |-> $past(start && !busy, 4), "result word with no header")

  // overflow saturates, otherwise the floor holds
  `ASSERT_CLK(a_saturate, (done && overflowed) |-> (next_work == '1), "overflow not saturated")
  `ASSERT_CLK(a_floor, (done && !overflowed) |-> (next_work >= MIN_WORK), "result below floor")

  // busy right after reset
  `ASSERT_ALWAYS(a_rst_busy, $past(rst) |-> busy, "not busy after reset")

endmodule

bind pow_difficulty_adjust_core pda_checker u_chk (.*);

`default_nettype wire
